### hw/rtl/assert_macros.svh
// Assertion helper macros used by the datapath of the cursor sequence buffer.
// Expects signals named clk and rst_n in the including module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge outside reset.
`define CSB_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition implies another one on the next edge.
`define CSB_ASSERT_NEXT(label, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);

`endif

### hw/rtl/csb_pkg.sv
// Shared types and codes for the cursor sequence buffer.
// No dependencies; used by the controller, the datapath and the top level.
package csb_pkg;

    localparam int DEF_CAPACITY   = 32;
    localparam int DEF_WORD_WIDTH = 32;
    localparam int ENTRY_W        = 32;
    localparam int WORD_MAX_W     = 64;
    localparam int CMD_W          = 3;
    localparam int COUNT_OUT_W    = 6;
    localparam int COUNT_EXT_W    = 16;

    // Command codes on the input channel
    localparam logic [CMD_W-1:0] CMD_START   = 3'd0;
    localparam logic [CMD_W-1:0] CMD_ADVANCE = 3'd1;
    localparam logic [CMD_W-1:0] CMD_INSERT  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_ATTACH  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_REMOVE  = 3'd4;

    // Datapath operations issued by the controller
    localparam int OP_W = 4;
    localparam logic [OP_W-1:0] DP_NOP      = 4'd0;
    localparam logic [OP_W-1:0] DP_LATCH    = 4'd1;
    localparam logic [OP_W-1:0] DP_START    = 4'd2;
    localparam logic [OP_W-1:0] DP_ADVANCE  = 4'd3;
    localparam logic [OP_W-1:0] DP_REJECT   = 4'd4;
    localparam logic [OP_W-1:0] DP_PREP_INS = 4'd5;
    localparam logic [OP_W-1:0] DP_PREP_ATT = 4'd6;
    localparam logic [OP_W-1:0] DP_SU_RD    = 4'd7;
    localparam logic [OP_W-1:0] DP_SU_WR    = 4'd8;
    localparam logic [OP_W-1:0] DP_PUT      = 4'd9;
    localparam logic [OP_W-1:0] DP_PREP_REM = 4'd10;
    localparam logic [OP_W-1:0] DP_SD_RD    = 4'd11;
    localparam logic [OP_W-1:0] DP_SD_WR    = 4'd12;
    localparam logic [OP_W-1:0] DP_REM_DONE = 4'd13;
    localparam logic [OP_W-1:0] DP_RD_CUR   = 4'd14;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            out_load;
    } csb_ctl_t;

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic             on_item;
        logic             full;
        logic             up_more;
        logic             down_more;
        logic             out_free;
    } csb_status_t;

endpackage

### hw/rtl/cursor_sequence_buffer.sv
// Top level of the cursor sequence buffer: an ordered word list with a cursor.
// Depends on csb_pkg, csb_ctrl and csb_datapath.
//
//   channel   dir   handshake              beat fields
//   --------  ----  ---------------------  -------------------------------------------
//   in        in    in_valid / in_ready    command, entry
//   out       out   out_valid / out_ready  current_word, has_current, entry_count,
//                                          rejected
//
// Sequence: for start, advance, a rejected insert or attach, a remove with no current item
//   and unknown commands the controller steps from accept through dispatch, RAM read and
//   result load, which waits until the output register is free; then the next command is taken.
// Insert and attach add a write of the new word plus a read and a write for each entry moved
//   up; removing the current entry adds a count update plus a read and a write for each entry
//   moved down, each through the single-port-pair storage RAM.
// Reset clears cursor, count and the result valid flag; storage contents stay undefined and
//   are never read before they are written, so no clearing pass is run.
// One command is in flight at a time; a finished result waits in the output register
//   while out_ready is low, and the next command is accepted meanwhile.
module cursor_sequence_buffer
    import csb_pkg::*;
#(
    parameter int CAPACITY   = DEF_CAPACITY,
    parameter int WORD_WIDTH = DEF_WORD_WIDTH
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [CMD_W-1:0]       command,
    input  logic [ENTRY_W-1:0]     entry,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [ENTRY_W-1:0]     current_word,
    output logic                   has_current,
    output logic [COUNT_OUT_W-1:0] entry_count,
    output logic                   rejected
);

    // command and status between the sequencer and the datapath
    csb_ctl_t    ctl;
    csb_status_t st;

    csb_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .st       (st),
        .ctl      (ctl)
    );

    csb_datapath #(
        .CAPACITY   (CAPACITY),
        .WORD_WIDTH (WORD_WIDTH)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctl          (ctl),
        .st           (st),
        .command      (command),
        .entry        (entry),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .current_word (current_word),
        .has_current  (has_current),
        .entry_count  (entry_count),
        .rejected     (rejected)
    );

endmodule

### hw/rtl/csb_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module csb_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

### hw/rtl/csb_ctrl.sv
// Controller state machine of the cursor sequence buffer.
// Depends on csb_pkg; drives the datapath by operation codes.
module csb_ctrl
    import csb_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  csb_status_t st,
    output csb_ctl_t    ctl
);

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_DISPATCH = 4'd1;
    localparam logic [3:0] S_SU_RD    = 4'd2;
    localparam logic [3:0] S_SU_WR    = 4'd3;
    localparam logic [3:0] S_SD_RD    = 4'd4;
    localparam logic [3:0] S_SD_WR    = 4'd5;
    localparam logic [3:0] S_READ     = 4'd6;
    localparam logic [3:0] S_RESP     = 4'd7;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next   = state_reg;
        ctl.op       = DP_NOP;
        ctl.out_load = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    ctl.op     = DP_LATCH;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                state_next = S_READ;
                case (st.cmd)
                    CMD_START:   ctl.op = DP_START;
                    CMD_ADVANCE: ctl.op = DP_ADVANCE;
                    CMD_INSERT:
                    begin
                        if (st.full)
                        begin
                            ctl.op = DP_REJECT;
                        end
                        else
                        begin
                            ctl.op     = DP_PREP_INS;
                            state_next = S_SU_RD;
                        end
                    end
                    CMD_ATTACH:
                    begin
                        if (st.full)
                        begin
                            ctl.op = DP_REJECT;
                        end
                        else
                        begin
                            ctl.op     = DP_PREP_ATT;
                            state_next = S_SU_RD;
                        end
                    end
                    CMD_REMOVE:
                    begin
                        if (st.on_item)
                        begin
                            ctl.op     = DP_PREP_REM;
                            state_next = S_SD_RD;
                        end
                    end
                    default: ctl.op = DP_NOP;
                endcase
            end
            S_SU_RD:
            begin
                // open the gap from the tail down, then drop the new word in
                if (st.up_more)
                begin
                    ctl.op     = DP_SU_RD;
                    state_next = S_SU_WR;
                end
                else
                begin
                    ctl.op     = DP_PUT;
                    state_next = S_READ;
                end
            end
            S_SU_WR:
            begin
                ctl.op     = DP_SU_WR;
                state_next = S_SU_RD;
            end
            S_SD_RD:
            begin
                if (st.down_more)
                begin
                    ctl.op     = DP_SD_RD;
                    state_next = S_SD_WR;
                end
                else
                begin
                    ctl.op     = DP_REM_DONE;
                    state_next = S_READ;
                end
            end
            S_SD_WR:
            begin
                ctl.op     = DP_SD_WR;
                state_next = S_SD_RD;
            end
            S_READ:
            begin
                ctl.op     = DP_RD_CUR;
                state_next = S_RESP;
            end
            S_RESP:
            begin
                if (st.out_free)
                begin
                    ctl.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

### hw/rtl/csb_datapath.sv
// Datapath of the cursor sequence buffer: cursor, count, shift index, storage, result beat.
// Depends on csb_pkg, csb_ram and assert_macros.svh.
`include "assert_macros.svh"

module csb_datapath
    import csb_pkg::*;
#(
    parameter int CAPACITY   = DEF_CAPACITY,
    parameter int WORD_WIDTH = DEF_WORD_WIDTH
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  csb_ctl_t               ctl,
    output csb_status_t            st,
    input  logic [CMD_W-1:0]       command,
    input  logic [ENTRY_W-1:0]     entry,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [ENTRY_W-1:0]     current_word,
    output logic                   has_current,
    output logic [COUNT_OUT_W-1:0] entry_count,
    output logic                   rejected
);

    localparam int ADDR_W = $clog2(CAPACITY);
    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);
    localparam logic [CNT_W-1:0] CNT_CAP = CNT_W'(CAPACITY);

    logic [CNT_W-1:0]      cursor_reg, cursor_next;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic [CNT_W-1:0]      idx_reg, idx_next;
    logic [CMD_W-1:0]      cmd_reg, cmd_next;
    logic [WORD_WIDTH-1:0] word_reg, word_next;
    logic                  rej_reg, rej_next;
    logic                  out_valid_reg;
    logic [ENTRY_W-1:0]    cur_word_reg;
    logic                  has_cur_reg;
    logic [COUNT_OUT_W-1:0] count_out_reg;
    logic                  rej_out_reg;

    logic [CNT_W-1:0]       idx_inc, idx_dec;
    logic                   on_item;
    logic [WORD_MAX_W-1:0]  entry_ext, rd_ext;
    logic [COUNT_EXT_W-1:0] count_ext;

    logic                  ram_wr_en, ram_rd_en;
    logic [ADDR_W-1:0]     ram_wr_addr, ram_rd_addr;
    logic [WORD_WIDTH-1:0] ram_wr_data, ram_rd_data;

    assign idx_inc   = idx_reg + CNT_ONE;
    assign idx_dec   = idx_reg - CNT_ONE;
    assign on_item   = (cursor_reg < count_reg);
    assign entry_ext = WORD_MAX_W'(entry);
    assign rd_ext    = WORD_MAX_W'(ram_rd_data);
    assign count_ext = COUNT_EXT_W'(count_reg);

    assign st.cmd       = cmd_reg;
    assign st.on_item   = on_item;
    assign st.full      = (count_reg == CNT_CAP);
    assign st.up_more   = (idx_reg > cursor_reg);
    assign st.down_more = (idx_inc < count_reg);
    assign st.out_free  = !out_valid_reg || out_ready;

    always_comb
    begin
        cursor_next = cursor_reg;
        count_next  = count_reg;
        idx_next    = idx_reg;
        cmd_next    = cmd_reg;
        word_next   = word_reg;
        rej_next    = rej_reg;
        ram_wr_en   = 1'b0;
        ram_wr_addr = idx_reg[ADDR_W-1:0];
        ram_wr_data = ram_rd_data;
        ram_rd_en   = 1'b0;
        ram_rd_addr = cursor_reg[ADDR_W-1:0];
        unique case (ctl.op)
            DP_LATCH:
            begin
                cmd_next  = command;
                word_next = entry_ext[WORD_WIDTH-1:0];
                rej_next  = 1'b0;
            end
            DP_START:
            begin
                cursor_next = '0;
            end
            DP_ADVANCE:
            begin
                if (on_item)
                begin
                    cursor_next = cursor_reg + CNT_ONE;
                end
            end
            DP_REJECT:
            begin
                rej_next = 1'b1;
            end
            DP_PREP_INS:
            begin
                cursor_next = on_item ? cursor_reg : '0;
                idx_next    = count_reg;
            end
            DP_PREP_ATT:
            begin
                cursor_next = on_item ? (cursor_reg + CNT_ONE) : count_reg;
                idx_next    = count_reg;
            end
            DP_SU_RD:
            begin
                ram_rd_en   = 1'b1;
                ram_rd_addr = idx_dec[ADDR_W-1:0];
            end
            DP_SU_WR:
            begin
                ram_wr_en = 1'b1;
                idx_next  = idx_dec;
            end
            DP_PUT:
            begin
                ram_wr_en   = 1'b1;
                ram_wr_addr = cursor_reg[ADDR_W-1:0];
                ram_wr_data = word_reg;
                count_next  = count_reg + CNT_ONE;
            end
            DP_PREP_REM:
            begin
                idx_next = cursor_reg;
            end
            DP_SD_RD:
            begin
                ram_rd_en   = 1'b1;
                ram_rd_addr = idx_inc[ADDR_W-1:0];
            end
            DP_SD_WR:
            begin
                ram_wr_en = 1'b1;
                idx_next  = idx_inc;
            end
            DP_REM_DONE:
            begin
                count_next = count_reg - CNT_ONE;
            end
            DP_RD_CUR:
            begin
                ram_rd_en = on_item;
            end
            default:
            begin
            end
        endcase
    end

    csb_ram #(
        .WIDTH (WORD_WIDTH),
        .DEPTH (CAPACITY)
    ) u_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cursor_reg    <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cursor_reg <= cursor_next;
            count_reg  <= count_next;
            if (ctl.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg  <= idx_next;
        cmd_reg  <= cmd_next;
        word_reg <= word_next;
        rej_reg  <= rej_next;
        if (ctl.out_load)
        begin
            cur_word_reg  <= on_item ? rd_ext[ENTRY_W-1:0] : '0;
            has_cur_reg   <= on_item;
            count_out_reg <= count_ext[COUNT_OUT_W-1:0];
            rej_out_reg   <= rej_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign current_word = cur_word_reg;
    assign has_current  = has_cur_reg;
    assign entry_count  = count_out_reg;
    assign rejected     = rej_out_reg;

    `CSB_ASSERT(a_count_bound, count_reg <= CNT_CAP, "count above capacity")
    `CSB_ASSERT(a_cursor_bound, cursor_reg <= count_reg, "cursor beyond count")
    `CSB_ASSERT_NEXT(a_put_grows, ctl.op == DP_PUT,
                     count_reg == $past(count_reg) + CNT_ONE, "insert did not grow count")

endmodule
